[rtl/gauss3d_derivative_kernel_unit_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the Gaussian derivative kernel unit
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef GAUSS3D_DERIVATIVE_KERNEL_UNIT_DEFINES_SVH
`define GAUSS3D_DERIVATIVE_KERNEL_UNIT_DEFINES_SVH

// same-cycle implication
`define G3DK_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define G3DK_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/g3dk_pkg.sv]
// ----------------------------------------------------------------------------
// g3dk_pkg
// Types and constants shared by the Gaussian derivative kernel pipeline.
// ----------------------------------------------------------------------------
package g3dk_pkg;

  localparam int NUM_STAGES = 12;
  localparam int ARG_STAGES = 6;
  localparam int SCL_STAGES = NUM_STAGES - ARG_STAGES;
  localparam int SIGMA_MAX  = 32;

  localparam logic [63:0] NORM_Q62   = 64'd292812713097000000;
  localparam logic [30:0] LOG2E_Q30  = 31'd1549082005;
  localparam logic [15:0] EXP_CUTOFF = 16'd48;

  // kernel select codes
  localparam logic [3:0] FN_GAUSS = 4'd0;
  localparam logic [3:0] FN_DX    = 4'd1;
  localparam logic [3:0] FN_DY    = 4'd2;
  localparam logic [3:0] FN_DZ    = 4'd3;
  localparam logic [3:0] FN_DXX   = 4'd4;
  localparam logic [3:0] FN_DYY   = 4'd5;
  localparam logic [3:0] FN_DZZ   = 4'd6;
  localparam logic [3:0] FN_DXY   = 4'd7;
  localparam logic [3:0] FN_DXZ   = 4'd8;
  localparam logic [3:0] FN_DYZ   = 4'd9;

  // normalization power class: s^3, s^5, s^7
  localparam logic [1:0] KC_3 = 2'd0;
  localparam logic [1:0] KC_5 = 2'd1;
  localparam logic [1:0] KC_7 = 2'd2;

  // 2^(-k/16), Q30, k = 0..16
  localparam logic [30:0] POW2_NEG_Q30 [17] = '{
    31'd1073741824, 31'd1028218693, 31'd984625594, 31'd942880699, 31'd902905651,
    31'd864625413,  31'd827968132,  31'd792865737, 31'd759250125, 31'd727060411,
    31'd696235434,  31'd666717336,  31'd638450708, 31'd611382493, 31'd585461881,
    31'd560640218,  31'd536870912
  };

  typedef struct packed {
    logic [10:0] s2;     // s^2
    logic [31:0] recip;  // floor(2^32 / (2 s^2))
    logic [58:0] k3;     // floor(norm / s^3)
    logic [58:0] k5;
    logic [58:0] k7;
  } g3dk_cfg_t;

  typedef struct packed {
    logic        bad;    // selector out of range
    logic        neg;    // polynomial factor negative
    logic [30:0] pm;     // |polynomial factor|, Q16
    logic [1:0]  kcls;
  } g3dk_side_t;

endpackage

[rtl/g3dk_pipe_ctl.sv]
// ----------------------------------------------------------------------------
// g3dk_pipe_ctl
// Valid bits and per-stage load enables; a stage loads when it is empty or
// the stage after it moves.
// ----------------------------------------------------------------------------
`include "gauss3d_derivative_kernel_unit_defines.svh"

module g3dk_pipe_ctl
  import g3dk_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [NUM_STAGES-1:0] en
);

  logic [NUM_STAGES-1:0] v_r;
  logic [NUM_STAGES-1:0] v_nxt;
  logic                  in_fire;
  logic                  out_fire;

  // stage i may load if the output drains or any stage at or above i is empty
  always_comb begin
    for (int i = 0; i < NUM_STAGES; i++) begin
      en[i] = out_tready | (|(~v_r & ({NUM_STAGES{1'b1}} << i)));
    end
  end

  always_comb begin
    v_nxt = v_r;
    for (int i = 0; i < NUM_STAGES; i++) begin
      if (en[i]) begin
        v_nxt[i] = (i == 0) ? in_tvalid : v_r[(i == 0) ? 0 : i - 1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_tready  = en[0];
  assign out_tvalid = v_r[NUM_STAGES-1];
  assign in_fire    = in_tvalid & in_tready;
  assign out_fire   = out_tvalid & out_tready;

  `G3DK_ASSERT_IMP(a_stall_only_full, !in_tready, &v_r,
    "input stalled with a bubble in the pipeline")
  `G3DK_ASSERT_NXT(a_held_not_lost, 1'b1,
    (v_r & $past(v_r & ~en)) == $past(v_r & ~en),
    "stalled item dropped")
  `G3DK_ASSERT_NXT(a_occupancy, 1'b1,
    ($countones(v_r) + int'($past(out_fire))) ==
    ($past($countones(v_r)) + int'($past(in_fire))),
    "pipeline occupancy does not match transfers")

endmodule

[rtl/g3dk_arg_path.sv]
// ----------------------------------------------------------------------------
// g3dk_arg_path
// Squares, polynomial factor, r2 / (2 s^2) and scaling by log2(e).
// ----------------------------------------------------------------------------
module g3dk_arg_path
  import g3dk_pkg::*;
(
  input  logic                  clk,
  input  logic [ARG_STAGES-1:0] en,
  input  g3dk_cfg_t             cfg,
  input  logic [3:0]            func,
  input  logic signed [15:0]    x_offset,
  input  logic signed [15:0]    y_offset,
  input  logic signed [15:0]    z_offset,
  output logic [31:0]           u,
  output g3dk_side_t            side
);

  // stage 0
  logic signed [31:0] sqx_w, sqy_w, sqz_w, prod_w;
  logic signed [15:0] pa_w, pb_w, a1_w;
  logic [3:0]         func_r0;
  logic [30:0]        sqx_r0, sqy_r0, sqz_r0;
  logic signed [31:0] prod_r0;
  logic signed [15:0] a1_r0;

  always_comb begin
    sqx_w = x_offset * x_offset;
    sqy_w = y_offset * y_offset;
    sqz_w = z_offset * z_offset;
    unique case (func)
      FN_DYY:  begin pa_w = y_offset; pb_w = y_offset; end
      FN_DZZ:  begin pa_w = z_offset; pb_w = z_offset; end
      FN_DXY:  begin pa_w = x_offset; pb_w = y_offset; end
      FN_DXZ:  begin pa_w = x_offset; pb_w = z_offset; end
      FN_DYZ:  begin pa_w = y_offset; pb_w = z_offset; end
      default: begin pa_w = x_offset; pb_w = x_offset; end
    endcase
    prod_w = pa_w * pb_w;
    unique case (func)
      FN_DY:   a1_w = y_offset;
      FN_DZ:   a1_w = z_offset;
      default: a1_w = x_offset;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      func_r0 <= func;
      sqx_r0  <= sqx_w[30:0];
      sqy_r0  <= sqy_w[30:0];
      sqz_r0  <= sqz_w[30:0];
      prod_r0 <= prod_w;
      a1_r0   <= a1_w;
    end
  end

  // stage 1
  logic [31:0]        r2_w;
  logic signed [32:0] p_w, pabs_w, a1x_w;
  g3dk_side_t         side_w;
  logic [31:0]        r2_r1;
  g3dk_side_t         side_r1;

  always_comb begin
    r2_w  = 32'(sqx_r0) + 32'(sqy_r0) + 32'(sqz_r0);
    a1x_w = 33'(a1_r0);
    side_w.bad  = 1'b0;
    side_w.kcls = KC_7;
    unique case (func_r0)
      FN_GAUSS: begin
        p_w = 33'sd65536;
        side_w.kcls = KC_3;
      end
      FN_DX, FN_DY, FN_DZ: begin
        p_w = -(a1x_w <<< 8);
        side_w.kcls = KC_5;
      end
      FN_DXX, FN_DYY, FN_DZZ: p_w = 33'(prod_r0) - $signed({6'd0, cfg.s2, 16'd0});
      FN_DXY, FN_DXZ, FN_DYZ: p_w = 33'(prod_r0);
      default: begin
        p_w = '0;
        side_w.bad = 1'b1;
      end
    endcase
    side_w.neg = p_w[32];
    pabs_w     = p_w[32] ? -p_w : p_w;
    side_w.pm  = pabs_w[30:0];
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      r2_r1   <= r2_w;
      side_r1 <= side_w;
    end
  end

  // stage 2: quotient estimate by reciprocal
  logic [63:0] qest_w;
  logic [31:0] q0_r2, r2_r2;
  g3dk_side_t  side_r2;

  assign qest_w = 64'(r2_r1) * 64'(cfg.recip);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      q0_r2   <= qest_w[63:32];
      r2_r2   <= r2_r1;
      side_r2 <= side_r1;
    end
  end

  // stage 3: back-multiply
  logic [11:0] div_w;
  logic [43:0] qd_w;
  logic [31:0] qd_r3, q0_r3, r2_r3;
  g3dk_side_t  side_r3;

  assign div_w = {cfg.s2, 1'b0};
  assign qd_w  = 44'(q0_r2) * 44'(div_w);

  always_ff @(posedge clk) begin
    if (en[3]) begin
      qd_r3   <= qd_w[31:0];
      q0_r3   <= q0_r2;
      r2_r3   <= r2_r2;
      side_r3 <= side_r2;
    end
  end

  // stage 4: estimate is low by at most one
  logic [31:0] rem_w, t_w, t_r4;
  g3dk_side_t  side_r4;

  assign rem_w = r2_r3 - qd_r3;
  assign t_w   = q0_r3 + 32'(rem_w >= 32'(div_w));

  always_ff @(posedge clk) begin
    if (en[4]) begin
      t_r4    <= t_w;
      side_r4 <= side_r3;
    end
  end

  // stage 5: u = t * log2(e), Q16
  logic [62:0] up_w;
  logic [31:0] u_r5;
  g3dk_side_t  side_r5;

  assign up_w = 63'(t_r4) * 63'(LOG2E_Q30);

  always_ff @(posedge clk) begin
    if (en[5]) begin
      u_r5    <= up_w[61:30];
      side_r5 <= side_r4;
    end
  end

  assign u    = u_r5;
  assign side = side_r5;

endmodule

[rtl/g3dk_scale_path.sv]
// ----------------------------------------------------------------------------
// g3dk_scale_path
// 2^-u by table and interpolation, normalization, polynomial factor and
// saturation to Q1.30.
// ----------------------------------------------------------------------------
module g3dk_scale_path
  import g3dk_pkg::*;
(
  input  logic                  clk,
  input  logic [SCL_STAGES-1:0] en,
  input  g3dk_cfg_t             cfg,
  input  logic [31:0]           u,
  input  g3dk_side_t            side,
  output logic [31:0]           kernel_value
);

  // stage 0: mantissa of 2^-frac
  logic [3:0]  idx_w;
  logic [11:0] fr_w;
  logic [30:0] t0_w, t1_w, m_w;
  logic [25:0] diff_w;
  logic [37:0] dm_w;
  logic [58:0] kk_w;
  logic [30:0] m_r0;
  logic [15:0] n_r0;
  logic [58:0] kk_r0;
  g3dk_side_t  side_r0;

  always_comb begin
    idx_w  = u[15:12];
    fr_w   = u[11:0];
    t0_w   = POW2_NEG_Q30[5'(idx_w)];
    t1_w   = POW2_NEG_Q30[5'(idx_w) + 5'd1];
    diff_w = 26'(t0_w - t1_w);
    dm_w   = 38'(diff_w) * 38'(fr_w);
    m_w    = t0_w - 31'(dm_w[37:12]);
    unique case (side.kcls)
      KC_3:    kk_w = cfg.k3;
      KC_5:    kk_w = cfg.k5;
      default: kk_w = cfg.k7;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      m_r0    <= m_w;
      n_r0    <= u[31:16];
      kk_r0   <= kk_w;
      side_r0 <= side;
    end
  end

  // stage 1: K * m as two partial products
  logic [62:0] plo_w;
  logic [57:0] phi_w;
  logic [30:0] plo_hi_r1;
  logic [57:0] phi_r1;
  logic [15:0] n_r1;
  g3dk_side_t  side_r1;

  assign plo_w = 63'(kk_r0[31:0]) * 63'(m_r0);
  assign phi_w = 58'(kk_r0[58:32]) * 58'(m_r0);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      plo_hi_r1 <= plo_w[62:32];
      phi_r1    <= phi_w;
      n_r1      <= n_r0;
      side_r1   <= side_r0;
    end
  end

  // stage 2: combine, drop to Q46
  logic [58:0] sum_w;
  logic [44:0] a0_r2;
  logic        cut_r2;
  logic [5:0]  sh_r2;
  g3dk_side_t  side_r2;

  assign sum_w = 59'(phi_r1) + 59'(plo_hi_r1);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      a0_r2   <= sum_w[58:14];
      cut_r2  <= n_r1 >= EXP_CUTOFF;
      sh_r2   <= n_r1[5:0];
      side_r2 <= side_r1;
    end
  end

  // stage 3: integer part of the exponent
  logic [44:0] a_r3;
  g3dk_side_t  side_r3;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      a_r3    <= cut_r2 ? '0 : (a0_r2 >> sh_r2);
      side_r3 <= side_r2;
    end
  end

  // stage 4: |P| * A as two partial products
  logic [62:0] lo_w;
  logic [43:0] hi_w;
  logic [30:0] lo_hi_r4;
  logic [43:0] hi_r4;
  g3dk_side_t  side_r4;

  assign lo_w = 63'(side_r3.pm) * 63'(a_r3[31:0]);
  assign hi_w = 44'(side_r3.pm) * 44'(a_r3[44:32]);

  always_ff @(posedge clk) begin
    if (en[4]) begin
      lo_hi_r4 <= lo_w[62:32];
      hi_r4    <= hi_w;
      side_r4  <= side_r3;
    end
  end

  // stage 5: sign and saturation
  logic [44:0] r_w, rneg_w;
  logic [31:0] kv_w, kv_r5;

  always_comb begin
    r_w    = 45'(hi_r4) + 45'(lo_hi_r4);
    rneg_w = -r_w;
    if (side_r4.bad) begin
      kv_w = '0;
    end else if (side_r4.neg) begin
      kv_w = (r_w > 45'h0_8000_0000) ? 32'h8000_0000 : rneg_w[31:0];
    end else begin
      kv_w = (r_w > 45'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : r_w[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      kv_r5 <= kv_w;
    end
  end

  assign kernel_value = kv_r5;

endmodule

[rtl/gauss3d_derivative_kernel_unit.sv]
// ----------------------------------------------------------------------------
// gauss3d_derivative_kernel_unit
// Normalized 3D Gaussian and its first and second partial derivatives.
// ----------------------------------------------------------------------------
// One kernel evaluation per clock unless stalled: a 12-stage pipeline accepts
// a point every cycle while in_tready is high. out_tready low stalls only as
// far back as there are no empty stages. The exponent division uses a
// reciprocal of 2*sigma^2 with one correction step, and the normalization
// factors 1/sigma^3, ^5, ^7 come from tables built at elaboration and loaded
// into a register on each sigma write. Items in flight read that register at
// several stages, so write sigma only while the pipeline is empty.
module gauss3d_derivative_kernel_unit
  import g3dk_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // x_offset[15:0], y_offset[31:16], z_offset[47:32]
  input  logic [3:0]  in_tuser,   // func[3:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // kernel_value[31:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [5:0]  cfg_data    // sigma
);

  g3dk_cfg_t tbl [SIGMA_MAX];

  for (genvar gi = 0; gi < SIGMA_MAX; gi++) begin : g_tbl
    localparam logic [63:0] S     = 64'(gi + 1);
    localparam logic [63:0] S2    = S * S;
    localparam logic [63:0] RECIP = 64'h1_0000_0000 / (2 * S * S);
    localparam logic [63:0] K3    = NORM_Q62 / (S * S * S);
    localparam logic [63:0] K5    = NORM_Q62 / (S * S * S * S * S);
    localparam logic [63:0] K7    = NORM_Q62 / (S * S * S * S * S * S * S);
    assign tbl[gi] = '{s2: S2[10:0], recip: RECIP[31:0],
                       k3: K3[58:0], k5: K5[58:0], k7: K7[58:0]};
  end

  // zero acts as one, above the top acts as the top
  function automatic logic [4:0] sigma_idx(input logic [5:0] v);
    logic [4:0] r;
    if (v == 6'd0) begin
      r = 5'd0;
    end else if (v > 6'(SIGMA_MAX)) begin
      r = 5'(SIGMA_MAX - 1);
    end else begin
      r = 5'(v - 6'd1);
    end
    return r;
  endfunction

  g3dk_cfg_t cfg_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= tbl[0];
    end else if (cfg_valid && cfg_ready) begin
      cfg_r <= tbl[sigma_idx(cfg_data)];
    end
  end

  logic [NUM_STAGES-1:0] en;
  logic [31:0]           u;
  g3dk_side_t            side;

  g3dk_pipe_ctl u_ctl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .en         (en)
  );

  g3dk_arg_path u_arg (
    .clk      (clk),
    .en       (en[ARG_STAGES-1:0]),
    .cfg      (cfg_r),
    .func     (in_tuser),
    .x_offset (in_tdata[15:0]),
    .y_offset (in_tdata[31:16]),
    .z_offset (in_tdata[47:32]),
    .u        (u),
    .side     (side)
  );

  g3dk_scale_path u_scl (
    .clk          (clk),
    .en           (en[NUM_STAGES-1:ARG_STAGES]),
    .cfg          (cfg_r),
    .u            (u),
    .side         (side),
    .kernel_value (out_tdata)
  );

endmodule
